// ----- design/fault_code_table_engine_assert.svh -----
// Assertion helpers for the fault code table engine.
`ifndef FAULT_CODE_TABLE_ENGINE_ASSERT_SVH
`define FAULT_CODE_TABLE_ENGINE_ASSERT_SVH

// Checked on every edge outside reset.
`define FCTE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define FCTE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/fcte_pkg.sv -----
// ----------------------------------------------------------------------------
// fcte_pkg
// Types and constants shared by the fault code table engine.
// ----------------------------------------------------------------------------
package fcte_pkg;

  localparam logic [3:0] CMD_REPORT     = 4'd0;
  localparam logic [3:0] CMD_CLEAR      = 4'd1;
  localparam logic [3:0] CMD_QUERY      = 4'd2;
  localparam logic [3:0] CMD_READ_IDX   = 4'd3;
  localparam logic [3:0] CMD_EVT_REPORT = 4'd4;
  localparam logic [3:0] CMD_EVT_READ   = 4'd5;
  localparam logic [3:0] CMD_EVT_RESET  = 4'd6;
  localparam logic [3:0] CMD_BUMP       = 4'd7;
  localparam logic [3:0] CMD_CLR_PEND   = 4'd8;
  localparam logic [3:0] CMD_LIST       = 4'd9;
  localparam logic [3:0] CMD_STATS      = 4'd10;

  localparam logic [2:0] CFG_ENABLE = 3'd0;
  localparam logic [2:0] CFG_FILTER = 3'd1;
  localparam logic [2:0] CFG_MAP0   = 3'd2;
  localparam int unsigned MAPPED_EVENTS = 5;

  localparam logic [1:0] FLT_OFF    = 2'd0;
  localparam logic [1:0] FLT_FAILED = 2'd1;
  localparam logic [1:0] FLT_ACTIVE = 2'd2;
  localparam logic [1:0] FLT_ALL    = 2'd3;

  localparam logic [7:0]  ST_FAILED    = 8'h01;
  localparam logic [7:0]  ST_PENDING   = 8'h02;
  localparam logic [7:0]  ST_CONFIRMED = 8'h04;
  localparam logic [15:0] FAIL_MAX     = 16'hFFFF;
  localparam logic [1:0]  EVT_SEVERITY = 2'd2;
  localparam logic [4:0]  MAX_RESULTS  = 5'd16;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] code;
    logic [1:0]  severity;
    logic [7:0]  event_id;
    logic        failed;
    logic [15:0] slot_index;
    logic [15:0] list_limit;
  } fcte_in_t;

  typedef struct packed {
    logic        result_code;
    logic [31:0] code_out;
    logic [7:0]  status_bits;
    logic [1:0]  severity_out;
    logic [31:0] occurrences;
    logic [15:0] failures;
    logic        active_flag;
    logic        occurred_flag;
    logic [4:0]  entry_count;
    logic [4:0]  active_total;
    logic [4:0]  historic_total;
    logic        last_item;
  } fcte_out_t;

  typedef struct packed {
    logic [31:0] code;
    logic [7:0]  status;
    logic [1:0]  severity;
    logic [31:0] occurrences;
    logic [15:0] failures;
    logic        active;
  } fcte_entry_t;

endpackage

// ----- design/fcte_ram.sv -----
// ----------------------------------------------------------------------------
// fcte_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fcte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fault_code_table_engine.sv -----
// ----------------------------------------------------------------------------
// fault_code_table_engine
// Compacted fault code table with event mapping, walked by one sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  in      | in_valid_i / in_stall_o   | in_data_i   (fcte_in_t)
//  out     | out_valid_o / out_stall_i | out_data_o  (fcte_out_t)
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Table lookup reads the entry RAM one entry at a time (read in S_SRD,
//  compare in S_SCMP); a clear then shifts each later entry down one slot.
//  Stats and clear-pending walk all entries in use; a list stops at its limit or MAX_RESULTS.
//  Reset empties the table at once (entry count to zero); no clearing pass.
//  The result beat sits in an output register; a stalled list waits there.
`include "fault_code_table_engine_assert.svh"

module fault_code_table_engine
  import fcte_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned EVENT_SLOTS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  fcte_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output fcte_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned EW = $clog2(EVENT_SLOTS);
  localparam int unsigned EW_ = $bits(fcte_entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_ACT, S_SHRD, S_SHWR,
    S_WRD, S_WCHK, S_WEND, S_IRD, S_ICAP, S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [3:0]        cmd_q, cmd_d;
  logic [31:0]       target_q, target_d;
  logic [1:0]        sev_q, sev_d;
  logic [15:0]       lim_q, lim_d;
  logic [4:0]        n_q, n_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     used_q, used_d;
  logic [CW-1:0]     act_q, act_d, his_q, his_d;
  logic              found_q, found_d;
  logic              pend_v_q, pend_v_d;
  logic [31:0]       pend_code_q, pend_code_d;
  fcte_entry_t       ent_q, ent_d;
  fcte_out_t         res_q, res_d;
  fcte_out_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [EVENT_SLOTS-1:0] ev_state_q, ev_state_d, ev_seen_q, ev_seen_d;
  logic              enable_q, enable_d;
  logic [1:0]        filter_q, filter_d;
  logic [31:0]       map_q [MAPPED_EVENTS];
  logic [31:0]       map_d [MAPPED_EVENTS];

  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  fcte_entry_t       ram_wdata, ram_rdata;

  logic              accept, out_free, ev_ok;
  logic [EW-1:0]     ev_idx;
  logic [31:0]       ev_map;
  logic [CW-1:0]     ptr_inc;
  fcte_entry_t       upd;

  fcte_ram #(.WIDTH(EW_), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic passes(input logic [1:0] mode, input fcte_entry_t e);
    logic r;
    case (mode)
      FLT_FAILED: r = (e.status & ST_FAILED) != 8'h00;
      FLT_ACTIVE: r = e.active;
      FLT_ALL:    r = 1'b1;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign ev_ok       = in_data_i.event_id < 8'(EVENT_SLOTS);
  assign ev_idx      = in_data_i.event_id[EW-1:0];
  assign ev_map      = (in_data_i.event_id < 8'(MAPPED_EVENTS)) ?
                       map_q[in_data_i.event_id[2:0]] : 32'd0;
  assign ptr_inc     = ptr_q + CW'(1);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    target_d    = target_q;
    sev_d       = sev_q;
    lim_d       = lim_q;
    n_d         = n_q;
    ptr_d       = ptr_q;
    used_d      = used_q;
    act_d       = act_q;
    his_d       = his_q;
    found_d     = found_q;
    pend_v_d    = pend_v_q;
    pend_code_d = pend_code_q;
    ent_d       = ent_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ev_state_d  = ev_state_q;
    ev_seen_d   = ev_seen_q;
    enable_d    = enable_q;
    filter_d    = filter_q;
    map_d       = map_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q[IW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = ptr_q[IW-1:0];
    upd         = ent_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLE: enable_d = cfg_data_i[0];
        CFG_FILTER: filter_d = cfg_data_i[1:0];
        default: begin
          if (cfg_index_i >= CFG_MAP0 && cfg_index_i < CFG_MAP0 + 3'(MAPPED_EVENTS)) begin
            map_d[cfg_index_i - CFG_MAP0] = cfg_data_i;
          end
        end
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d             = in_data_i.command;
          target_d          = in_data_i.code;
          sev_d             = in_data_i.severity;
          lim_d             = in_data_i.list_limit;
          ptr_d             = '0;
          n_d               = '0;
          act_d             = '0;
          his_d             = '0;
          pend_v_d          = 1'b0;
          res_d             = '0;
          res_d.result_code = 1'b1;
          state_d           = S_OUT;
          case (in_data_i.command)
            CMD_REPORT: begin
              if (enable_q) state_d = S_SRD;
            end
            CMD_CLEAR: begin
              if (in_data_i.code == 32'd0) begin
                used_d            = '0;
                res_d.result_code = 1'b0;
              end else begin
                state_d = S_SRD;
              end
            end
            CMD_QUERY: state_d = S_SRD;
            CMD_READ_IDX: begin
              if (in_data_i.slot_index < 16'(used_q)) begin
                ptr_d   = CW'(in_data_i.slot_index);
                state_d = S_IRD;
              end
            end
            CMD_EVT_REPORT: begin
              if (enable_q && ev_ok) begin
                ev_state_d[ev_idx] = in_data_i.failed;
                ev_seen_d[ev_idx]  = 1'b1;
                res_d.result_code  = 1'b0;
                if (in_data_i.failed && ev_map != 32'd0) begin
                  target_d = ev_map;
                  sev_d    = EVT_SEVERITY;
                  state_d  = S_SRD;
                end
              end
            end
            CMD_EVT_READ: begin
              if (ev_ok) begin
                res_d.result_code   = 1'b0;
                res_d.status_bits   = {7'd0, ev_state_q[ev_idx]};
                res_d.occurred_flag = ev_seen_q[ev_idx];
              end
            end
            CMD_EVT_RESET: begin
              if (ev_ok) begin
                ev_state_d[ev_idx] = 1'b0;
                ev_seen_d[ev_idx]  = 1'b0;
                res_d.result_code  = 1'b0;
              end
            end
            CMD_BUMP: begin
              if (ev_ok && ev_map != 32'd0) begin
                target_d = ev_map;
                state_d  = S_SRD;
              end
            end
            CMD_CLR_PEND, CMD_LIST, CMD_STATS: state_d = S_WRD;
            default: ;
          endcase
        end
      end

      // lookup: issue read, then compare one entry
      S_SRD: begin
        if (ptr_q >= used_q) begin
          found_d = 1'b0;
          state_d = S_ACT;
        end else begin
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (ram_rdata.code == target_q) begin
          found_d = 1'b1;
          ent_d   = ram_rdata;
          state_d = S_ACT;
        end else begin
          ptr_d   = ptr_inc;
          state_d = S_SRD;
        end
      end

      S_ACT: begin
        state_d = S_OUT;
        case (cmd_q)
          CMD_REPORT, CMD_EVT_REPORT: begin
            res_d.result_code = 1'b0;
            if (found_q) begin
              upd.status      = ent_q.status | ST_FAILED;
              upd.occurrences = ent_q.occurrences + 32'd1;
              upd.active      = 1'b1;
              ram_we          = 1'b1;
              ram_wdata       = upd;
            end else if (used_q >= CW'(TABLE_DEPTH)) begin
              res_d.result_code = (cmd_q == CMD_REPORT);
            end else begin
              upd.code        = target_q;
              upd.status      = ST_FAILED | ST_CONFIRMED;
              upd.severity    = sev_q;
              upd.occurrences = 32'd1;
              upd.failures    = 16'd1;
              upd.active      = 1'b1;
              ram_we          = 1'b1;
              ram_waddr       = used_q[IW-1:0];
              ram_wdata       = upd;
              used_d          = used_q + CW'(1);
            end
          end
          CMD_CLEAR: begin
            if (found_q) state_d = S_SHRD;
          end
          CMD_QUERY: begin
            if (found_q) begin
              res_d.result_code  = 1'b0;
              res_d.code_out     = ent_q.code;
              res_d.status_bits  = ent_q.status;
              res_d.severity_out = ent_q.severity;
              res_d.occurrences  = ent_q.occurrences;
              res_d.failures     = ent_q.failures;
              res_d.active_flag  = ent_q.active;
            end
          end
          CMD_BUMP: begin
            if (found_q) begin
              if (ent_q.failures != FAIL_MAX) upd.failures = ent_q.failures + 16'd1;
              ram_we            = 1'b1;
              ram_wdata         = upd;
              res_d.result_code = 1'b0;
            end
          end
          default: ;
        endcase
      end

      // compaction: move entry ptr+1 down to ptr
      S_SHRD: begin
        ram_raddr = ptr_inc[IW-1:0];
        if (ptr_inc < used_q) begin
          state_d = S_SHWR;
        end else begin
          used_d            = used_q - CW'(1);
          res_d.result_code = 1'b0;
          state_d           = S_OUT;
        end
      end
      S_SHWR: begin
        ram_we  = 1'b1;
        ptr_d   = ptr_inc;
        state_d = S_SHRD;
      end

      S_WRD: begin
        if (ptr_q >= used_q || (cmd_q == CMD_LIST &&
            ({11'd0, n_q} >= lim_q || n_q >= MAX_RESULTS))) begin
          state_d = S_WEND;
        end else begin
          state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        ptr_d   = ptr_inc;
        state_d = S_WRD;
        case (cmd_q)
          CMD_CLR_PEND: begin
            ram_we           = 1'b1;
            ram_wdata.status = ram_rdata.status & ~ST_PENDING;
          end
          CMD_STATS: begin
            if (ram_rdata.active) act_d = act_q + CW'(1);
            else                  his_d = his_q + CW'(1);
          end
          default: begin
            if (passes(filter_q, ram_rdata)) begin
              if (pend_v_q && !out_free) begin
                ptr_d   = ptr_q;
                state_d = S_WCHK;
              end else begin
                if (pend_v_q) begin
                  out_d             = '0;
                  out_d.code_out    = pend_code_q;
                  out_d.entry_count = 5'(used_q);
                  out_valid_d       = 1'b1;
                end
                pend_v_d    = 1'b1;
                pend_code_d = ram_rdata.code;
                n_d         = n_q + 5'd1;
              end
            end
          end
        endcase
      end
      S_WEND: begin
        case (cmd_q)
          CMD_LIST: begin
            if (!pend_v_q) begin
              state_d = S_IDLE;
            end else if (out_free) begin
              out_d             = '0;
              out_d.code_out    = pend_code_q;
              out_d.entry_count = 5'(used_q);
              out_d.last_item   = 1'b1;
              out_valid_d       = 1'b1;
              pend_v_d          = 1'b0;
              state_d           = S_IDLE;
            end
          end
          CMD_STATS: begin
            res_d.result_code    = 1'b0;
            res_d.active_total   = 5'(act_q);
            res_d.historic_total = 5'(his_q);
            state_d              = S_OUT;
          end
          default: begin
            res_d.result_code = 1'b0;
            state_d           = S_OUT;
          end
        endcase
      end

      S_IRD: state_d = S_ICAP;
      S_ICAP: begin
        res_d.result_code = 1'b0;
        res_d.code_out    = ram_rdata.code;
        state_d           = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_d             = res_q;
          out_d.entry_count = 5'(used_q);
          out_d.last_item   = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      pend_v_q    <= 1'b0;
      ev_state_q  <= '0;
      ev_seen_q   <= '0;
      enable_q    <= 1'b0;
      filter_q    <= FLT_OFF;
      for (int i = 0; i < MAPPED_EVENTS; i++) map_q[i] <= 32'd0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      pend_v_q    <= pend_v_d;
      ev_state_q  <= ev_state_d;
      ev_seen_q   <= ev_seen_d;
      enable_q    <= enable_d;
      filter_q    <= filter_d;
      map_q       <= map_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    target_q    <= target_d;
    sev_q       <= sev_d;
    lim_q       <= lim_d;
    n_q         <= n_d;
    ptr_q       <= ptr_d;
    act_q       <= act_d;
    his_q       <= his_d;
    found_q     <= found_d;
    pend_code_q <= pend_code_d;
    ent_q       <= ent_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  `FCTE_ASSERT(a_used_bound, used_q <= CW'(TABLE_DEPTH), "entry count beyond table depth")
  `FCTE_ASSERT(a_idle_no_pend, (state_q == S_IDLE) |-> !pend_v_q, "list beat left behind")
  `FCTE_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy after accept")

endmodule

// ----- tb/sv/fcte_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcte_checker
// Watches the command, result and register channels of the fault code table
// engine. Keeps its own copy of the table and events, predicts the result
// beats of every accepted command, and compares them in order.
// ----------------------------------------------------------------------------
module fcte_checker
  import fcte_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  fcte_in_t    in_data_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  fcte_out_t   out_data_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          result_cnt_o
);

  localparam int DEPTH = 16;
  localparam int SLOTS = 10;

  fcte_entry_t tbl[DEPTH];
  int          used;
  logic        ev_failed[SLOTS];
  logic        ev_seen[SLOTS];
  logic        en;
  logic [1:0]  filt;
  logic [31:0] map_code[MAPPED_EVENTS];
  fcte_out_t   results_q[$];

  assign pending_o = results_q.size();

  function automatic int find_code(logic [31:0] c);
    for (int i = 0; i < used; i++) begin
      if (tbl[i].code == c) return i;
    end
    return -1;
  endfunction

  function automatic logic [31:0] event_code(logic [7:0] ev);
    return (ev < MAPPED_EVENTS) ? map_code[ev] : 32'd0;
  endfunction

  function automatic logic report_fault(logic [31:0] c, logic [1:0] sev);
    int k;
    if (!en) return 1'b1;
    k = find_code(c);
    if (k >= 0) begin
      tbl[k].status      = tbl[k].status | ST_FAILED;
      tbl[k].occurrences = tbl[k].occurrences + 32'd1;
      tbl[k].active      = 1'b1;
      return 1'b0;
    end
    if (used >= DEPTH) return 1'b1;
    tbl[used].code        = c;
    tbl[used].status      = ST_FAILED | ST_CONFIRMED;
    tbl[used].severity    = sev;
    tbl[used].occurrences = 32'd1;
    tbl[used].failures    = 16'd1;
    tbl[used].active      = 1'b1;
    used++;
    return 1'b0;
  endfunction

  function automatic logic listed(int i);
    case (filt)
      FLT_FAILED: return (tbl[i].status & ST_FAILED) != 0;
      FLT_ACTIVE: return tbl[i].active;
      FLT_ALL:    return 1'b1;
      default:    return 1'b0;
    endcase
  endfunction

  task automatic predict_results(fcte_in_t c);
    fcte_out_t r;
    int        k;
    int        n;
    r = '0;
    r.result_code = 1'b1;
    case (c.command)
      CMD_REPORT: r.result_code = report_fault(c.code, c.severity);
      CMD_CLEAR: begin
        if (c.code == 0) begin
          used = 0;
          r.result_code = 1'b0;
        end else begin
          k = find_code(c.code);
          if (k >= 0) begin
            for (int j = k; j + 1 < used; j++) tbl[j] = tbl[j + 1];
            used--;
            r.result_code = 1'b0;
          end
        end
      end
      CMD_QUERY: begin
        k = find_code(c.code);
        if (k >= 0) begin
          r.result_code  = 1'b0;
          r.code_out     = tbl[k].code;
          r.status_bits  = tbl[k].status;
          r.severity_out = tbl[k].severity;
          r.occurrences  = tbl[k].occurrences;
          r.failures     = tbl[k].failures;
          r.active_flag  = tbl[k].active;
        end
      end
      CMD_READ_IDX: begin
        if (c.slot_index < used) begin
          r.result_code = 1'b0;
          r.code_out    = tbl[c.slot_index].code;
        end
      end
      CMD_EVT_REPORT: begin
        if (en && c.event_id < SLOTS) begin
          ev_failed[c.event_id] = c.failed;
          ev_seen[c.event_id]   = 1'b1;
          // a refused mapped report still answers ok
          if (c.failed && event_code(c.event_id) != 0)
            void'(report_fault(event_code(c.event_id), EVT_SEVERITY));
          r.result_code = 1'b0;
        end
      end
      CMD_EVT_READ: begin
        if (c.event_id < SLOTS) begin
          r.result_code   = 1'b0;
          r.status_bits   = {7'd0, ev_failed[c.event_id]};
          r.occurred_flag = ev_seen[c.event_id];
        end
      end
      CMD_EVT_RESET: begin
        if (c.event_id < SLOTS) begin
          ev_failed[c.event_id] = 1'b0;
          ev_seen[c.event_id]   = 1'b0;
          r.result_code = 1'b0;
        end
      end
      CMD_BUMP: begin
        if (c.event_id < SLOTS && event_code(c.event_id) != 0) begin
          k = find_code(event_code(c.event_id));
          if (k >= 0) begin
            if (tbl[k].failures < FAIL_MAX) tbl[k].failures = tbl[k].failures + 16'd1;
            r.result_code = 1'b0;
          end
        end
      end
      CMD_CLR_PEND: begin
        for (int i = 0; i < used; i++) tbl[i].status = tbl[i].status & ~ST_PENDING;
        r.result_code = 1'b0;
      end
      CMD_LIST: begin
        n = 0;
        for (int i = 0; i < used && n < c.list_limit && n < MAX_RESULTS; i++) begin
          if (listed(i)) begin
            r = '0;
            r.code_out    = tbl[i].code;
            r.entry_count = used[4:0];
            results_q.push_back(r);
            n++;
          end
        end
        if (n > 0) results_q[$].last_item = 1'b1;
        return;
      end
      CMD_STATS: begin
        r.result_code = 1'b0;
        for (int i = 0; i < used; i++) begin
          if (tbl[i].active) r.active_total++;
          else r.historic_total++;
        end
      end
      default: ;
    endcase
    r.entry_count = used[4:0];
    r.last_item   = 1'b1;
    results_q.push_back(r);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  task automatic check_beat(fcte_out_t a);
    fcte_out_t e;
    if (results_q.size() == 0) begin
      $display("%0t: unexpected result beat, expected none actual %h", $time, a);
      fail_cnt_o++;
      return;
    end
    e = results_q.pop_front();
    check_field("result_code", e.result_code, a.result_code);
    check_field("code_out", e.code_out, a.code_out);
    check_field("status_bits", e.status_bits, a.status_bits);
    check_field("severity_out", e.severity_out, a.severity_out);
    check_field("occurrences", e.occurrences, a.occurrences);
    check_field("failures", e.failures, a.failures);
    check_field("active_flag", e.active_flag, a.active_flag);
    check_field("occurred_flag", e.occurred_flag, a.occurred_flag);
    check_field("entry_count", e.entry_count, a.entry_count);
    check_field("active_total", e.active_total, a.active_total);
    check_field("historic_total", e.historic_total, a.historic_total);
    check_field("last_item", e.last_item, a.last_item);
  endtask

  initial begin
    fail_cnt_o   = 0;
    result_cnt_o = 0;
    used         = 0;
    en           = 1'b0;
    filt         = FLT_OFF;
    for (int i = 0; i < SLOTS; i++) begin
      ev_failed[i] = 1'b0;
      ev_seen[i]   = 1'b0;
    end
    for (int i = 0; i < MAPPED_EVENTS; i++) map_code[i] = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        result_cnt_o++;
        check_beat(out_data_o);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_ENABLE) en = cfg_data_i[0];
        else if (cfg_index_i == CFG_FILTER) filt = cfg_data_i[1:0];
        else if (cfg_index_i >= CFG_MAP0 && cfg_index_i < CFG_MAP0 + MAPPED_EVENTS)
          map_code[cfg_index_i - CFG_MAP0] = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) predict_results(in_data_i);
    end
  end

endmodule

// ----- tb/sv/fault_code_table_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fault_code_table_engine_tb
// Drives directed and random commands through the fault code table engine
// under several register settings and idle patterns; the checker predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module fault_code_table_engine_tb;
  import fcte_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  fcte_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  fcte_out_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  int fail_cnt;
  int pending;
  int result_cnt;
  int cmd_cnt;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;

  fault_code_table_engine i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o,
    .out_stall_i, .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  fcte_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o,
    .out_stall_i, .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .result_cnt_o(result_cnt)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) out_stall_i <= hold_off;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Any accepted beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("fault_code_table_engine_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_cmd(fcte_in_t c);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cmd_cnt++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // an empty listing gives no beat, so let any walk finish
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic fcte_in_t make_cmd(logic [3:0] op, logic [31:0] code,
                                        logic [7:0] ev, logic [15:0] idx,
                                        logic [15:0] lim);
    fcte_in_t c;
    c.command    = op;
    c.code       = code;
    c.severity   = 2'($urandom);
    c.event_id   = ev;
    c.failed     = 1'($urandom);
    c.slot_index = idx;
    c.list_limit = lim;
    return c;
  endfunction

  function automatic logic [31:0] pick_code();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  function automatic fcte_in_t random_cmd();
    fcte_in_t   c;
    logic [3:0] op;
    int         r;
    r = $urandom_range(99);
    if (r < 35) op = CMD_REPORT;
    else if (r < 45) op = CMD_CLEAR;
    else if (r < 50) op = CMD_EVT_REPORT;
    else if (r < 96) op = 4'($urandom_range(CMD_QUERY, CMD_STATS));
    else op = 4'($urandom_range(11, 15));
    c = make_cmd(op, pick_code(), 8'($urandom_range(0, 11)),
                 16'($urandom_range(0, 17)), 16'($urandom_range(0, 18)));
    if ($urandom_range(9) == 0) c.event_id = 8'($urandom);
    if ($urandom_range(9) == 0) c.slot_index = 16'($urandom);
    if ($urandom_range(9) == 0) c.list_limit = 16'($urandom);
    if (op == CMD_CLEAR && $urandom_range(9) == 0) c.code = '0;
    c.failed = ($urandom_range(3) != 0);
    return c;
  endfunction

  initial begin
    fcte_in_t c;
    fail_cnt       = 0;
    cmd_cnt        = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_ENABLE;
    cfg_data_i     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled: reports refused, other commands still answer
    send_cmd(make_cmd(CMD_REPORT, 32'd5, 8'd0, 16'd0, 16'd1));
    send_cmd(make_cmd(CMD_EVT_REPORT, 32'd0, 8'd1, 16'd0, 16'd1));
    send_cmd(make_cmd(CMD_READ_IDX, 32'd0, 8'd0, 16'hFFFF, 16'd0));
    drain();
    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_FILTER, {30'd0, FLT_ALL});
    write_reg(CFG_MAP0, 32'hFFFF_FFFF);
    write_reg(CFG_MAP0 + 3'd1, 32'd7);
    write_reg(CFG_MAP0 + 3'd2, 32'd0);
    write_reg(CFG_MAP0 + 3'd3, 32'd3);
    write_reg(CFG_MAP0 + 3'd4, 32'hA5A5_5A5A);
    send_cmd(make_cmd(CMD_REPORT, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_REPORT, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_QUERY, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_EVT_REPORT, 32'd0, 8'd1, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_EVT_REPORT, 32'd0, 8'd9, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_EVT_READ, 32'd0, 8'd255, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_EVT_READ, 32'd0, 8'd1, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_BUMP, 32'd0, 8'd1, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_BUMP, 32'd0, 8'd2, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_EVT_RESET, 32'd0, 8'd10, 16'd0, 16'd0));
    for (int i = 1; i <= 15; i++)
      send_cmd(make_cmd(CMD_REPORT, 32'd100 + i, 8'd0, 16'd0, 16'd0));
    // table full now
    send_cmd(make_cmd(CMD_REPORT, 32'd999, 8'd0, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_LIST, 32'd0, 8'd0, 16'd0, 16'hFFFF));
    send_cmd(make_cmd(CMD_CLEAR, 32'd101, 8'd0, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_CLEAR, 32'd999, 8'd0, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_READ_IDX, 32'd0, 8'd0, 16'd14, 16'd0));
    send_cmd(make_cmd(CMD_CLR_PEND, 32'd0, 8'd0, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_STATS, 32'd0, 8'd0, 16'd0, 16'd0));
    send_cmd(make_cmd(4'd15, 32'd0, 8'd0, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_LIST, 32'd0, 8'd0, 16'd0, 16'd0));
    send_cmd(make_cmd(CMD_CLEAR, 32'd0, 8'd0, 16'd0, 16'd0));

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(CFG_FILTER, 32'(ph));
      write_reg(CFG_ENABLE, (ph == 2) ? 32'd0 : 32'd1);
      for (int m = 0; m < MAPPED_EVENTS; m++)
        write_reg(CFG_MAP0 + 3'(m), ($urandom_range(3) == 0) ? 32'd0 : pick_code());
      send_idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 32 : 0;
      recv_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 32 : 0;
      if (ph == 1) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 16; n++) begin
        c = random_cmd();
        send_cmd(c);
      end
    end
    drain();

    $display("Ran %0d commands and checked %0d result beats over four register settings",
             cmd_cnt, result_cnt);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (fail_cnt == 0) begin
      $display("fault_code_table_engine_tb: clean");
    end else begin
      $display("fault_code_table_engine_tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/fcte_pkg.sv
design/fcte_ram.sv
design/fault_code_table_engine.sv
tb/sv/fcte_checker.sv
tb/sv/fault_code_table_engine_tb.sv
